@@ src/drd_pkg.sv @@
// types, codes and constants shared by the delta record decoder
`timescale 1ns / 1ps

package drd_pkg;

  localparam int VALUE_SLOTS     = 128;
  localparam int IDX_W           = $clog2(VALUE_SLOTS);
  localparam int FIELD_BYTES     = VALUE_SLOTS / 8;
  localparam int FBYTE_W         = $clog2(FIELD_BYTES);
  localparam int VALUE_WIDTH_DEF = 16;
  localparam int OUT_VALUE_W     = 16;

  localparam logic [7:0]  DEFAULT_VALUE  = 8'hF0;
  localparam int          MODE_FAST      = 2;
  localparam int          MODE_STANDARD  = 3;
  localparam logic [15:0] SIGN_SKIP_MASK = 16'h00C0;

  localparam logic KIND_VALUE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CHECKSUM = 2'd1;
  localparam logic [1:0] ST_MAPS     = 2'd2;

  typedef enum logic [3:0] {
    PH_WAIT,
    PH_M0H,
    PH_M0L,
    PH_M1H,
    PH_M1L,
    PH_REP,
    PH_FMAP,
    PH_SMAP,
    PH_DELTA,
    PH_CHECK,
    PH_ERR
  } phase_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_DELTA,
    OP_CHECK_OK,
    OP_CHECK_FAIL,
    OP_MAPERR
  } op_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       flight_start;
  } byte_item_t;

  typedef struct packed {
    logic                           result_kind;
    logic [IDX_W-1:0]               value_index;
    logic signed [OUT_VALUE_W-1:0]  value_out;
    logic [1:0]                     status;
    logic                           is_fast;
  } result_item_t;

  function automatic logic is_zero_slot(input logic [IDX_W-1:0] idx);
    logic z;
    case (idx)
      7'd30, 7'd42, 7'd44, 7'd48, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd55,
      7'd56, 7'd57, 7'd58, 7'd59, 7'd60, 7'd61, 7'd62, 7'd63, 7'd76, 7'd77, 7'd79,
      7'd86, 7'd87, 7'd100, 7'd101, 7'd103, 7'd108, 7'd109, 7'd110, 7'd116, 7'd117,
      7'd118: z = 1'b1;
      default: z = 1'b0;
    endcase
    return z;
  endfunction

endpackage

@@ src/delta_record_decoder.sv @@
// delta record decoder: byte parser, value store and result register
// a result moves through the execute stage registers into the output register; the value
// store is read at accept and written by execute; one byte per cycle unless execute stalls
// reset: synchronous; clears parser state, fast flag, mark index and the 128 entry valid bits
// an entry without its valid bit reads as its load default, so the store needs no clearing pass
`timescale 1ns / 1ps

module delta_record_decoder #(
  parameter int VALUE_WIDTH = drd_pkg::VALUE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        byte_valid,
  output logic                        byte_ready,
  input  drd_pkg::byte_item_t         byte_item,
  output logic                        result_valid,
  input  logic                        result_ready,
  output drd_pkg::result_item_t       result_item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [drd_pkg::IDX_W-1:0]   cfg_data
);

  localparam int VW = VALUE_WIDTH;
  localparam int NS = drd_pkg::VALUE_SLOTS;
  localparam int IW = drd_pkg::IDX_W;
  localparam int BW = drd_pkg::FBYTE_W;

  function automatic logic [4:0] next_set(input logic [15:0] m, input logic [4:0] from);
    logic [4:0] r;
    r = 5'b00000;
    for (int i = 15; i >= 0; i--) begin
      if (m[i] && (5'(i) >= from)) begin
        r = {1'b1, 4'(i)};
      end
    end
    return r;
  endfunction

  // parser state
  drd_pkg::phase_t phase, phase_next, cur_ph;
  logic [15:0]   first_map, first_map_next;
  logic [7:0]    held_byte, held_byte_next;
  logic [3:0]    header_count, header_count_next;
  logic [NS-1:0] field_bits, field_bits_next;
  logic [NS-1:0] sign_bits, sign_bits_next;
  logic [7:0]    byte_sum, byte_sum_next;
  logic [7:0]    byte_xor, byte_xor_next;
  logic          first_record, first_record_next;
  logic [NS-1:0] init_map, init_map_next;
  logic [NS-1:0] loaded, loaded_next;
  logic [IW-1:0] mark_index;

  logic          byte_fire;
  drd_pkg::op_t  s1_op;
  logic          s1_rd_en;
  logic [IW-1:0] s1_rd_addr;
  logic          s1_sign;
  logic [NS-1:0] fb0, sb0, fb_upd, sb_upd;
  logic [7:0]    sum0, xor0;
  logic [4:0]    fld_from, sgn_from, fld_srch, sgn_srch;
  logic [BW-1:0] low_byte;
  logic [2:0]    low_bit;
  logic [7:0]    low_bits;
  logic [IW-1:0] del_idx;
  logic          begin_deltas;

  // value store and read stage
  logic [VW-1:0] mem [NS];
  logic [VW-1:0] rd_data;
  logic          rd_loaded;
  logic          rd_dflt;
  logic          fwd_hit;
  logic [VW-1:0] fwd_val;

  // execute stage
  logic          s2_valid;
  drd_pkg::op_t  s2_op;
  logic [IW-1:0] s2_idx;
  logic [7:0]    s2_d;
  logic          s2_sign;
  logic          s2_needs_out, s2_go, s2_wr;
  logic signed [VW-1:0] base;
  logic signed [VW+1:0] ext, sum_v;
  logic          ovf;
  logic [VW-1:0] s2_wval;
  logic signed [31:0] wval32;
  logic          fast_flag, fast_next;
  drd_pkg::result_item_t res_next;

  assign cfg_ready  = 1'b1;
  assign byte_ready = !s2_valid || s2_go;
  assign byte_fire  = byte_valid && byte_ready;

  assign cur_ph = byte_item.flight_start ? drd_pkg::PH_M0H : phase;
  assign fb0    = (cur_ph == drd_pkg::PH_M0H) ? '0 : field_bits;
  assign sb0    = (cur_ph == drd_pkg::PH_M0H) ? '0 : sign_bits;
  assign sum0   = (cur_ph == drd_pkg::PH_M0H) ? 8'h00 : byte_sum;
  assign xor0   = (cur_ph == drd_pkg::PH_M0H) ? 8'h00 : byte_xor;

  assign fld_from = (cur_ph == drd_pkg::PH_FMAP) ? ({1'b0, header_count} + 5'd1) : 5'd0;
  assign sgn_from = (cur_ph == drd_pkg::PH_SMAP) ? ({1'b0, header_count} + 5'd1) : 5'd0;
  assign fld_srch = next_set(first_map, fld_from);
  assign sgn_srch = next_set(first_map & ~drd_pkg::SIGN_SKIP_MASK, sgn_from);

  // lowest pending field bit, byte first then bit
  always_comb begin
    low_byte = '0;
    for (int k = drd_pkg::FIELD_BYTES - 1; k >= 0; k--) begin
      if (|field_bits[k*8 +: 8]) begin
        low_byte = BW'(k);
      end
    end
    low_bits = field_bits[{low_byte, 3'b000} +: 8];
    low_bit  = '0;
    for (int j = 7; j >= 0; j--) begin
      if (low_bits[j]) begin
        low_bit = 3'(j);
      end
    end
    del_idx = {low_byte, low_bit};
  end

  always_comb begin
    fb_upd = fb0;
    sb_upd = sb0;
    if (cur_ph == drd_pkg::PH_FMAP) begin
      fb_upd[{header_count, 3'b000} +: 8] = fb0[{header_count, 3'b000} +: 8] |
                                             byte_item.data_byte;
    end
    if (cur_ph == drd_pkg::PH_SMAP) begin
      sb_upd[{header_count, 3'b000} +: 8] = sb0[{header_count, 3'b000} +: 8] |
                                             byte_item.data_byte;
    end
  end

  always_comb begin
    phase_next        = phase;
    first_map_next    = first_map;
    held_byte_next    = held_byte;
    header_count_next = header_count;
    field_bits_next   = field_bits;
    sign_bits_next    = sign_bits;
    byte_sum_next     = byte_sum;
    byte_xor_next     = byte_xor;
    first_record_next = first_record;
    init_map_next     = init_map;
    loaded_next       = loaded;
    s1_op             = drd_pkg::OP_NONE;
    s1_rd_en          = 1'b0;
    s1_rd_addr        = mark_index;
    s1_sign           = 1'b0;
    begin_deltas      = 1'b0;

    if (s2_wr) begin
      loaded_next[s2_idx] = 1'b1;
    end

    if (byte_fire) begin
      if (byte_item.flight_start) begin
        first_record_next = 1'b1;
        phase_next        = drd_pkg::PH_M0H;
        s1_op             = drd_pkg::OP_CLEAR;
      end
      if (cur_ph != drd_pkg::PH_WAIT && cur_ph != drd_pkg::PH_ERR) begin
        field_bits_next = fb0;
        sign_bits_next  = sb0;
        if (cur_ph != drd_pkg::PH_CHECK) begin
          byte_sum_next = sum0 + byte_item.data_byte;
          byte_xor_next = xor0 ^ byte_item.data_byte;
        end
      end
      case (cur_ph)
        drd_pkg::PH_M0H: begin
          first_map_next = {byte_item.data_byte, 8'h00};
          phase_next     = drd_pkg::PH_M0L;
        end
        drd_pkg::PH_M0L: begin
          first_map_next = {first_map[15:8], byte_item.data_byte};
          phase_next     = drd_pkg::PH_M1H;
        end
        drd_pkg::PH_M1H: begin
          held_byte_next = byte_item.data_byte;
          phase_next     = drd_pkg::PH_M1L;
        end
        drd_pkg::PH_M1L: begin
          if ({held_byte, byte_item.data_byte} != first_map) begin
            phase_next = drd_pkg::PH_ERR;
            s1_op      = drd_pkg::OP_MAPERR;
          end else begin
            phase_next = drd_pkg::PH_REP;
          end
        end
        drd_pkg::PH_REP, drd_pkg::PH_FMAP: begin
          field_bits_next = fb_upd;
          if (fld_srch[4]) begin
            header_count_next = fld_srch[3:0];
            phase_next        = drd_pkg::PH_FMAP;
          end else if (sgn_srch[4]) begin
            header_count_next = sgn_srch[3:0];
            phase_next        = drd_pkg::PH_SMAP;
          end else begin
            begin_deltas = 1'b1;
          end
        end
        drd_pkg::PH_SMAP: begin
          sign_bits_next = sb_upd;
          if (sgn_srch[4]) begin
            header_count_next = sgn_srch[3:0];
            phase_next        = drd_pkg::PH_SMAP;
          end else begin
            begin_deltas = 1'b1;
          end
        end
        drd_pkg::PH_DELTA: begin
          if (field_bits == '0) begin
            phase_next = drd_pkg::PH_CHECK;
          end else begin
            field_bits_next[del_idx] = 1'b0;
            s1_op      = drd_pkg::OP_DELTA;
            s1_rd_en   = 1'b1;
            s1_rd_addr = del_idx;
            s1_sign    = sign_bits[del_idx];
            if (field_bits_next == '0) begin
              phase_next = drd_pkg::PH_CHECK;
            end
          end
        end
        drd_pkg::PH_CHECK: begin
          if (byte_item.data_byte == (8'h00 - byte_sum) || byte_item.data_byte == byte_xor) begin
            s1_op             = drd_pkg::OP_CHECK_OK;
            s1_rd_en          = 1'b1;
            s1_rd_addr        = mark_index;
            first_record_next = 1'b0;
            phase_next        = drd_pkg::PH_M0H;
          end else begin
            s1_op      = drd_pkg::OP_CHECK_FAIL;
            phase_next = drd_pkg::PH_ERR;
          end
        end
        default: begin
        end
      endcase
      if (begin_deltas) begin
        phase_next = (fb_upd != '0) ? drd_pkg::PH_DELTA : drd_pkg::PH_CHECK;
        if (first_record) begin
          loaded_next   = '0;
          init_map_next = fb_upd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= drd_pkg::PH_WAIT;
      first_map    <= '0;
      held_byte    <= '0;
      header_count <= '0;
      field_bits   <= '0;
      sign_bits    <= '0;
      byte_sum     <= '0;
      byte_xor     <= '0;
      first_record <= 1'b1;
      init_map     <= '0;
      loaded       <= '0;
      mark_index   <= '0;
    end else begin
      phase        <= phase_next;
      first_map    <= first_map_next;
      held_byte    <= held_byte_next;
      header_count <= header_count_next;
      field_bits   <= field_bits_next;
      sign_bits    <= sign_bits_next;
      byte_sum     <= byte_sum_next;
      byte_xor     <= byte_xor_next;
      first_record <= first_record_next;
      init_map     <= init_map_next;
      loaded       <= loaded_next;
      if (cfg_valid) begin
        mark_index <= cfg_data;
      end
    end
  end

  // value store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (s2_wr) begin
      mem[s2_idx] <= s2_wval;
    end
    if (byte_fire && s1_rd_en) begin
      rd_data   <= mem[s1_rd_addr];
      rd_loaded <= loaded[s1_rd_addr];
      rd_dflt   <= init_map[s1_rd_addr] && !drd_pkg::is_zero_slot(s1_rd_addr);
      fwd_hit   <= s2_wr && (s2_idx == s1_rd_addr);
      fwd_val   <= s2_wval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (byte_fire) begin
      s2_valid <= (s1_op != drd_pkg::OP_NONE);
    end else if (s2_go) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_fire) begin
      s2_op   <= s1_op;
      s2_idx  <= s1_rd_addr;
      s2_d    <= byte_item.data_byte;
      s2_sign <= s1_sign;
    end
  end

  always_comb begin
    s2_needs_out = (s2_op == drd_pkg::OP_DELTA) || (s2_op == drd_pkg::OP_CHECK_OK) ||
                   (s2_op == drd_pkg::OP_CHECK_FAIL) || (s2_op == drd_pkg::OP_MAPERR);
    s2_go = s2_valid && (!s2_needs_out || !result_valid || result_ready);
    s2_wr = s2_go && (s2_op == drd_pkg::OP_DELTA);

    if (fwd_hit) begin
      base = $signed(fwd_val);
    end else if (rd_loaded) begin
      base = $signed(rd_data);
    end else if (rd_dflt) begin
      base = $signed(VW'(drd_pkg::DEFAULT_VALUE));
    end else begin
      base = '0;
    end

    ext   = (VW+2)'(base);
    sum_v = s2_sign ? (ext - $signed((VW+2)'(s2_d))) : (ext + $signed((VW+2)'(s2_d)));
    ovf   = !((sum_v[VW+1:VW-1] == 3'b000) || (sum_v[VW+1:VW-1] == 3'b111));
    s2_wval = ovf ? {sum_v[VW+1], {(VW-1){~sum_v[VW+1]}}} : sum_v[VW-1:0];
    wval32  = 32'($signed(s2_wval));

    fast_next = fast_flag;
    case (s2_op)
      drd_pkg::OP_CLEAR: fast_next = 1'b0;
      drd_pkg::OP_CHECK_OK: begin
        if (base == VW'(drd_pkg::MODE_FAST)) begin
          fast_next = 1'b1;
        end else if (base == VW'(drd_pkg::MODE_STANDARD)) begin
          fast_next = 1'b0;
        end
      end
      default: begin
      end
    endcase

    res_next.result_kind = drd_pkg::KIND_STATUS;
    res_next.value_index = '0;
    res_next.value_out   = '0;
    res_next.status      = drd_pkg::ST_OK;
    res_next.is_fast     = fast_next;
    case (s2_op)
      drd_pkg::OP_DELTA: begin
        res_next.result_kind = drd_pkg::KIND_VALUE;
        res_next.value_index = s2_idx;
        res_next.value_out   = wval32[drd_pkg::OUT_VALUE_W-1:0];
      end
      drd_pkg::OP_CHECK_FAIL: res_next.status = drd_pkg::ST_CHECKSUM;
      drd_pkg::OP_MAPERR:     res_next.status = drd_pkg::ST_MAPS;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_flag    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (s2_go) begin
        fast_flag <= fast_next;
      end
      if (s2_go && s2_needs_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s2_needs_out) begin
      result_item <= res_next;
    end
  end

endmodule
